/* rtl/vml_pkg.sv */
// Shared constants, types and helper functions of the look-at view matrix block.
`timescale 1ns / 1ps
`default_nettype none
package vml_pkg;

   // Default number format of the coordinates.
   localparam int FRAC_BITS_DEF   = 16;
   localparam int COORD_WIDTH_DEF = 32;

   // Vectors are scaled so that the largest magnitude lies in [2^SCALE_LOW, 2^SCALE_TOP).
   localparam int SCALE_LOW = 29;
   localparam int SCALE_TOP = 30;

   // Working width of magnitudes before scaling, and of a bit position in it.
   localparam int MAG_W  = 64;
   localparam int LEAD_W = 6;

   // Rows emitted for each item; the accept throttle spaces items so that each has room for them.
   localparam int ROW_COUNT = 3;

   typedef logic [1:0] row_type;
   localparam row_type ROW_X = 2'd0;
   localparam row_type ROW_Y = 2'd1;
   localparam row_type ROW_Z = 2'd2;

   // Magnitude of a sign-extended value.
   function automatic logic [MAG_W-1:0] mag_of(input logic signed [MAG_W-1:0] v);
      logic [MAG_W-1:0] m;
      m = v[MAG_W-1] ? MAG_W'(-v) : MAG_W'(v);
      return m;
   endfunction

   // Position of the highest set bit; zero for a zero word.
   function automatic logic [LEAD_W-1:0] lead_pos(input logic [MAG_W-1:0] v);
      logic [LEAD_W-1:0] p;
      p = '0;
      for (int i = 0; i < MAG_W; i++) begin
         if (v[i]) begin
            p = LEAD_W'(i);
         end
      end
      return p;
   endfunction

   // Shift a magnitude so that a leading one at pos lands on bit SCALE_LOW.
   function automatic logic [SCALE_TOP-1:0] scale_mag(input logic [MAG_W-1:0] mag,
                                                      input logic [LEAD_W-1:0] pos);
      logic [MAG_W-1:0] sh;
      if (pos >= LEAD_W'(SCALE_LOW)) begin
         sh = mag >> (pos - LEAD_W'(SCALE_LOW));
      end else begin
         sh = mag << (LEAD_W'(SCALE_LOW) - pos);
      end
      return sh[SCALE_TOP-1:0];
   endfunction

endpackage
`default_nettype wire

/* rtl/vml_norm.sv */
// Pipelined vector normalizer: scale, square sum, square root and three divisions.
`timescale 1ns / 1ps
`default_nettype none
module vml_norm #(
   parameter int IN_W      = 33,
   parameter int FRAC_BITS = 16,
   parameter int SIDE_W    = 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic signed [IN_W-1:0]      in_vec [3],
   input  logic [SIDE_W-1:0]           in_side,
   output logic                        out_valid,
   output logic                        out_nonzero,
   output logic signed [FRAC_BITS+1:0] out_unit [3],
   output logic [SIDE_W-1:0]           out_side
);
   import vml_pkg::*;

   localparam int M_W      = SCALE_TOP;
   localparam int SQ_STEPS = SCALE_TOP + 1;
   localparam int SQ_W     = 2 * SQ_STEPS;
   localparam int RT_W     = SQ_W + 1;
   localparam int LEN_W    = SQ_STEPS;
   localparam int QW       = FRAC_BITS + 1;
   localparam int DW       = SCALE_TOP + FRAC_BITS + 2;
   localparam int UW       = FRAC_BITS + 2;
   localparam int NEG_LSB  = 3 * M_W;
   localparam int NZ_BIT   = 3 * M_W + 3;
   localparam int SIDE_LSB = 3 * M_W + 4;
   localparam int CAR_W    = 3 * M_W + 4 + SIDE_W;

   // Stage 1: magnitudes and signs.
   logic [MAG_W-1:0]  s1_mag_ff [3];
   logic [2:0]        s1_neg_ff;
   logic [SIDE_W-1:0] s1_side_ff;
   logic              s1_vld_ff;
   // Stage 2: leading one of the largest magnitude.
   logic [MAG_W-1:0]  s2_mag_ff [3];
   logic [2:0]        s2_neg_ff;
   logic [SIDE_W-1:0] s2_side_ff;
   logic [LEAD_W-1:0] s2_pos_ff;
   logic              s2_nz_ff;
   logic              s2_vld_ff;
   // Stage 3 onward: scaled magnitudes travel in one carry word.
   logic [CAR_W-1:0]  s3_car_ff;
   logic              s3_vld_ff;
   logic [2*M_W-1:0]  s4_sq_ff [3];
   logic [CAR_W-1:0]  s4_car_ff;
   logic              s4_vld_ff;
   // Square root, one result bit per stage.
   logic [SQ_W-1:0]   sq_x_ff   [SQ_STEPS+1];
   logic [RT_W-1:0]   sq_r_ff   [SQ_STEPS+1];
   logic [CAR_W-1:0]  sq_car_ff [SQ_STEPS+1];
   logic [SQ_STEPS:0] sq_vld_ff;
   logic [SQ_W-1:0]   sq_x_in   [SQ_STEPS];
   logic [RT_W-1:0]   sq_r_in   [SQ_STEPS];
   // Division, one quotient bit per stage, three lanes.
   logic [DW-1:0]     dv_rem_ff [QW+1][3];
   logic [QW-1:0]     dv_q_ff   [QW+1][3];
   logic [LEN_W-1:0]  dv_len_ff [QW+1];
   logic [CAR_W-1:0]  dv_car_ff [QW+1];
   logic [QW:0]       dv_vld_ff;
   logic [DW-1:0]     dv_rem_in [QW][3];
   logic [QW-1:0]     dv_q_in   [QW][3];
   // Output stage.
   logic signed [UW-1:0] out_unit_ff [3];
   logic                 out_nz_ff;
   logic [SIDE_W-1:0]    out_side_ff;
   logic                 out_vld_ff;

   logic [MAG_W-1:0] s1_or;
   logic [LEN_W-1:0] sq_len;

   assign s1_or  = s1_mag_ff[0] | s1_mag_ff[1] | s1_mag_ff[2];
   assign sq_len = sq_r_ff[SQ_STEPS][LEN_W-1:0];

   always_comb begin
      logic [RT_W-1:0] sq_bit;
      logic [RT_W-1:0] trial;
      for (int k = 0; k < SQ_STEPS; k++) begin
         sq_bit = RT_W'(1) << (2 * (SQ_STEPS - 1 - k));
         trial  = sq_r_ff[k] + sq_bit;
         if (RT_W'(sq_x_ff[k]) >= trial) begin
            sq_x_in[k] = sq_x_ff[k] - trial[SQ_W-1:0];
            sq_r_in[k] = (sq_r_ff[k] >> 1) + sq_bit;
         end else begin
            sq_x_in[k] = sq_x_ff[k];
            sq_r_in[k] = sq_r_ff[k] >> 1;
         end
      end
   end

   always_comb begin
      logic [DW-1:0] dvsr;
      for (int j = 0; j < QW; j++) begin
         dvsr = DW'(dv_len_ff[j]) << (QW - 1 - j);
         for (int i = 0; i < 3; i++) begin
            if (dv_rem_ff[j][i] >= dvsr) begin
               dv_rem_in[j][i] = dv_rem_ff[j][i] - dvsr;
               dv_q_in[j][i]   = dv_q_ff[j][i] | (QW'(1) << (QW - 1 - j));
            end else begin
               dv_rem_in[j][i] = dv_rem_ff[j][i];
               dv_q_in[j][i]   = dv_q_ff[j][i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         s4_vld_ff  <= 1'b0;
         sq_vld_ff  <= '0;
         dv_vld_ff  <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= in_valid;
         s2_vld_ff  <= s1_vld_ff;
         s3_vld_ff  <= s2_vld_ff;
         s4_vld_ff  <= s3_vld_ff;
         sq_vld_ff  <= {sq_vld_ff[SQ_STEPS-1:0], s4_vld_ff};
         dv_vld_ff  <= {dv_vld_ff[QW-1:0], sq_vld_ff[SQ_STEPS]};
         out_vld_ff <= dv_vld_ff[QW];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         s1_mag_ff[i] <= mag_of(MAG_W'(in_vec[i]));
         s1_neg_ff[i] <= in_vec[i][IN_W-1];
         s2_mag_ff[i] <= s1_mag_ff[i];
         s3_car_ff[i*M_W +: M_W] <= scale_mag(s2_mag_ff[i], s2_pos_ff);
         s4_sq_ff[i]  <= s3_car_ff[i*M_W +: M_W] * s3_car_ff[i*M_W +: M_W];
      end
      s1_side_ff <= in_side;
      s2_neg_ff  <= s1_neg_ff;
      s2_side_ff <= s1_side_ff;
      s2_pos_ff  <= lead_pos(s1_or);
      s2_nz_ff   <= |s1_or;
      s3_car_ff[NEG_LSB +: 3]       <= s2_neg_ff;
      s3_car_ff[NZ_BIT]             <= s2_nz_ff;
      s3_car_ff[SIDE_LSB +: SIDE_W] <= s2_side_ff;
      s4_car_ff  <= s3_car_ff;

      sq_x_ff[0]   <= SQ_W'(s4_sq_ff[0]) + SQ_W'(s4_sq_ff[1]) + SQ_W'(s4_sq_ff[2]);
      sq_r_ff[0]   <= '0;
      sq_car_ff[0] <= s4_car_ff;
      for (int k = 0; k < SQ_STEPS; k++) begin
         sq_x_ff[k+1]   <= sq_x_in[k];
         sq_r_ff[k+1]   <= sq_r_in[k];
         sq_car_ff[k+1] <= sq_car_ff[k];
      end

      // Numerator carries half the length so that the quotient rounds to nearest.
      for (int i = 0; i < 3; i++) begin
         dv_rem_ff[0][i] <= (DW'(sq_car_ff[SQ_STEPS][i*M_W +: M_W]) << FRAC_BITS)
                            + DW'(sq_len >> 1);
         dv_q_ff[0][i]   <= '0;
      end
      dv_len_ff[0] <= sq_len;
      dv_car_ff[0] <= sq_car_ff[SQ_STEPS];
      for (int j = 0; j < QW; j++) begin
         for (int i = 0; i < 3; i++) begin
            dv_rem_ff[j+1][i] <= dv_rem_in[j][i];
            dv_q_ff[j+1][i]   <= dv_q_in[j][i];
         end
         dv_len_ff[j+1] <= dv_len_ff[j];
         dv_car_ff[j+1] <= dv_car_ff[j];
      end

      for (int i = 0; i < 3; i++) begin
         if (dv_car_ff[QW][NEG_LSB + i]) begin
            out_unit_ff[i] <= UW'(0) - UW'(dv_q_ff[QW][i]);
         end else begin
            out_unit_ff[i] <= UW'(dv_q_ff[QW][i]);
         end
      end
      out_nz_ff   <= dv_car_ff[QW][NZ_BIT];
      out_side_ff <= dv_car_ff[QW][SIDE_LSB +: SIDE_W];
   end

   assign out_valid   = out_vld_ff;
   assign out_nonzero = out_nz_ff;
   assign out_unit    = out_unit_ff;
   assign out_side    = out_side_ff;

endmodule
`default_nettype wire

/* rtl/view_matrix_lookat.sv */
// Top level of the look-at view matrix generator.
`timescale 1ns / 1ps
`default_nettype none
// The block takes one item (eye point, target point and up vector, signed fixed point) when
// start is high and busy is low, and then emits three result items on consecutive cycles,
// each marked by rsp_strobe for one cycle: the X row, the Y row, then the Z row with
// rsp_last_row set. The receiver cannot hold results off, so every row must be taken in the
// cycle it is shown. Each item occupies the single result port for its three rows, so busy
// stays high after an accept and the block cannot take a new item until it falls; the
// pipeline itself moves every cycle and several items are in flight at once. Three
// normalizers, each a 31-stage square root followed by a (FRAC_BITS+1)-stage divider, make up
// most of the pipeline. An item whose Z, X or Y axis has zero length comes out with zero axes
// and translations and rsp_degenerate set on all three rows. Translations that do not fit the
// coordinate width saturate. There is no state to clear after reset.
module view_matrix_lookat #(
   parameter int FRAC_BITS   = vml_pkg::FRAC_BITS_DEF,
   parameter int COORD_WIDTH = vml_pkg::COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COORD_WIDTH-1:0] req_eye_x,
   input  logic signed [COORD_WIDTH-1:0] req_eye_y,
   input  logic signed [COORD_WIDTH-1:0] req_eye_z,
   input  logic signed [COORD_WIDTH-1:0] req_target_x,
   input  logic signed [COORD_WIDTH-1:0] req_target_y,
   input  logic signed [COORD_WIDTH-1:0] req_target_z,
   input  logic signed [COORD_WIDTH-1:0] req_upvec_x,
   input  logic signed [COORD_WIDTH-1:0] req_upvec_y,
   input  logic signed [COORD_WIDTH-1:0] req_upvec_z,
   output logic                          rsp_strobe,
   output vml_pkg::row_type              rsp_row_index,
   output logic signed [FRAC_BITS+1:0]   rsp_axis_a,
   output logic signed [FRAC_BITS+1:0]   rsp_axis_b,
   output logic signed [FRAC_BITS+1:0]   rsp_axis_c,
   output logic signed [COORD_WIDTH-1:0] rsp_translation,
   output logic                          rsp_degenerate,
   output logic                          rsp_last_row
);
   import vml_pkg::*;

   localparam int CW    = COORD_WIDTH;
   localparam int UW    = FRAC_BITS + 2;
   localparam int DZ_W  = CW + 1;
   localparam int UPS_W = SCALE_TOP + 1;
   localparam int P1_W  = UPS_W + UW;
   localparam int XR_W  = P1_W + 1;
   localparam int P2_W  = 2 * UW;
   localparam int YR_W  = P2_W + 1;
   localparam int DP_W  = UW + CW;
   localparam int DS_W  = DP_W + 2;
   localparam int GAP_W = $clog2(ROW_COUNT);
   // Carry word after Z: {ok, Z axis, eye}. After X: {ok, X axis, Z axis, eye}.
   localparam int ZSIDE_W = 6 * CW;
   localparam int CB_W    = 3 * CW + 3 * UW + 1;
   localparam int CC_W    = 3 * CW + 6 * UW + 1;
   localparam logic signed [DS_W:0] T_MAX = {{(DS_W + 2 - CW){1'b0}}, {(CW - 1){1'b1}}};
   localparam logic signed [DS_W:0] T_MIN = {{(DS_W + 2 - CW){1'b1}}, {(CW - 1){1'b0}}};
   localparam logic signed [DS_W:0] T_HALF = (DS_W + 1)'(1) << (FRAC_BITS - 1);

   // Accept throttle: spaces accepted items so that each has room for the three rows it produces.
   logic [GAP_W-1:0] gap_ff;
   logic             accept;

   assign busy   = (gap_ff != '0);
   assign accept = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff <= '0;
      end else if (accept) begin
         gap_ff <= GAP_W'(ROW_COUNT - 1);
      end else if (gap_ff != '0) begin
         gap_ff <= gap_ff - GAP_W'(1);
      end
   end

   // Input stage: register the eye, the up vector and eye minus target.
   logic                  a_vld_ff;
   logic signed [CW-1:0]  a_eye_ff [3];
   logic signed [CW-1:0]  a_up_ff  [3];
   logic signed [DZ_W-1:0] a_d_ff  [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      a_eye_ff[0] <= req_eye_x;
      a_eye_ff[1] <= req_eye_y;
      a_eye_ff[2] <= req_eye_z;
      a_up_ff[0]  <= req_upvec_x;
      a_up_ff[1]  <= req_upvec_y;
      a_up_ff[2]  <= req_upvec_z;
      a_d_ff[0]   <= DZ_W'(req_eye_x) - DZ_W'(req_target_x);
      a_d_ff[1]   <= DZ_W'(req_eye_y) - DZ_W'(req_target_y);
      a_d_ff[2]   <= DZ_W'(req_eye_z) - DZ_W'(req_target_z);
   end

   // Z axis.
   logic                 z_vld;
   logic                 z_nz;
   logic signed [UW-1:0] z_unit [3];
   logic [ZSIDE_W-1:0]   z_side;

   vml_norm #(
      .IN_W      (DZ_W),
      .FRAC_BITS (FRAC_BITS),
      .SIDE_W    (ZSIDE_W)
   ) u_norm_z (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (a_vld_ff),
      .in_vec      (a_d_ff),
      .in_side     ({a_up_ff[2], a_up_ff[1], a_up_ff[0],
                     a_eye_ff[2], a_eye_ff[1], a_eye_ff[0]}),
      .out_valid   (z_vld),
      .out_nonzero (z_nz),
      .out_unit    (z_unit),
      .out_side    (z_side)
   );

   // Scale the up vector the same way a length is prepared; only its direction matters.
   logic signed [CW-1:0]  z_up [3];
   logic [MAG_W-1:0]      u1_mag_ff [3];
   logic [2:0]            u1_neg_ff;
   logic [CB_W-1:0]       u1_cb_ff;
   logic                  u1_vld_ff;
   logic [MAG_W-1:0]      u2_mag_ff [3];
   logic [2:0]            u2_neg_ff;
   logic [LEAD_W-1:0]     u2_pos_ff;
   logic [CB_W-1:0]       u2_cb_ff;
   logic                  u2_vld_ff;
   logic signed [UPS_W-1:0] u3_ups_ff [3];
   logic [CB_W-1:0]       u3_cb_ff;
   logic                  u3_vld_ff;
   logic [SCALE_TOP-1:0]  u2_m [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         z_up[i] = z_side[(3 + i) * CW +: CW];
         u2_m[i] = scale_mag(u2_mag_ff[i], u2_pos_ff);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         u1_mag_ff[i] <= mag_of(MAG_W'(z_up[i]));
         u1_neg_ff[i] <= z_up[i][CW-1];
         u2_mag_ff[i] <= u1_mag_ff[i];
         if (u2_neg_ff[i]) begin
            u3_ups_ff[i] <= UPS_W'(0) - UPS_W'(u2_m[i]);
         end else begin
            u3_ups_ff[i] <= UPS_W'(u2_m[i]);
         end
      end
      u1_cb_ff  <= {z_nz, z_unit[2], z_unit[1], z_unit[0], z_side[3*CW-1:0]};
      u2_neg_ff <= u1_neg_ff;
      u2_pos_ff <= lead_pos(u1_mag_ff[0] | u1_mag_ff[1] | u1_mag_ff[2]);
      u2_cb_ff  <= u1_cb_ff;
      u3_cb_ff  <= u2_cb_ff;
   end

   // Cross product up x Z: products first, differences in the next stage.
   logic signed [UW-1:0]   u3_z [3];
   logic signed [P1_W-1:0] c1_p_ff [6];
   logic [CB_W-1:0]        c1_cb_ff;
   logic                   c1_vld_ff;
   logic signed [XR_W-1:0] c2_xr_ff [3];
   logic [CB_W-1:0]        c2_cb_ff;
   logic                   c2_vld_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         u3_z[i] = u3_cb_ff[3 * CW + i * UW +: UW];
      end
   end

   always_ff @(posedge clock) begin
      c1_p_ff[0]  <= u3_ups_ff[1] * u3_z[2];
      c1_p_ff[1]  <= u3_ups_ff[2] * u3_z[1];
      c1_p_ff[2]  <= u3_ups_ff[2] * u3_z[0];
      c1_p_ff[3]  <= u3_ups_ff[0] * u3_z[2];
      c1_p_ff[4]  <= u3_ups_ff[0] * u3_z[1];
      c1_p_ff[5]  <= u3_ups_ff[1] * u3_z[0];
      c1_cb_ff    <= u3_cb_ff;
      c2_xr_ff[0] <= XR_W'(c1_p_ff[0]) - XR_W'(c1_p_ff[1]);
      c2_xr_ff[1] <= XR_W'(c1_p_ff[2]) - XR_W'(c1_p_ff[3]);
      c2_xr_ff[2] <= XR_W'(c1_p_ff[4]) - XR_W'(c1_p_ff[5]);
      c2_cb_ff    <= c1_cb_ff;
   end

   // X axis.
   logic                 x_vld;
   logic                 x_nz;
   logic signed [UW-1:0] x_unit [3];
   logic [CB_W-1:0]      x_side;

   vml_norm #(
      .IN_W      (XR_W),
      .FRAC_BITS (FRAC_BITS),
      .SIDE_W    (CB_W)
   ) u_norm_x (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (c2_vld_ff),
      .in_vec      (c2_xr_ff),
      .in_side     (c2_cb_ff),
      .out_valid   (x_vld),
      .out_nonzero (x_nz),
      .out_unit    (x_unit),
      .out_side    (x_side)
   );

   // Cross product Z x X.
   logic signed [UW-1:0]   xs_z [3];
   logic signed [P2_W-1:0] c3_p_ff [6];
   logic [CC_W-1:0]        c3_cc_ff;
   logic                   c3_vld_ff;
   logic signed [YR_W-1:0] c4_yr_ff [3];
   logic [CC_W-1:0]        c4_cc_ff;
   logic                   c4_vld_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         xs_z[i] = x_side[3 * CW + i * UW +: UW];
      end
   end

   always_ff @(posedge clock) begin
      c3_p_ff[0]  <= xs_z[1] * x_unit[2];
      c3_p_ff[1]  <= xs_z[2] * x_unit[1];
      c3_p_ff[2]  <= xs_z[2] * x_unit[0];
      c3_p_ff[3]  <= xs_z[0] * x_unit[2];
      c3_p_ff[4]  <= xs_z[0] * x_unit[1];
      c3_p_ff[5]  <= xs_z[1] * x_unit[0];
      c3_cc_ff    <= {x_side[CB_W-1] & x_nz, x_unit[2], x_unit[1], x_unit[0],
                      x_side[CB_W-2:0]};
      c4_yr_ff[0] <= YR_W'(c3_p_ff[0]) - YR_W'(c3_p_ff[1]);
      c4_yr_ff[1] <= YR_W'(c3_p_ff[2]) - YR_W'(c3_p_ff[3]);
      c4_yr_ff[2] <= YR_W'(c3_p_ff[4]) - YR_W'(c3_p_ff[5]);
      c4_cc_ff    <= c3_cc_ff;
   end

   // Y axis.
   logic                 y_vld;
   logic                 y_nz;
   logic signed [UW-1:0] y_unit [3];
   logic [CC_W-1:0]      y_side;

   vml_norm #(
      .IN_W      (YR_W),
      .FRAC_BITS (FRAC_BITS),
      .SIDE_W    (CC_W)
   ) u_norm_y (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (c4_vld_ff),
      .in_vec      (c4_yr_ff),
      .in_side     (c4_cc_ff),
      .out_valid   (y_vld),
      .out_nonzero (y_nz),
      .out_unit    (y_unit),
      .out_side    (y_side)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         u1_vld_ff <= 1'b0;
         u2_vld_ff <= 1'b0;
         u3_vld_ff <= 1'b0;
         c1_vld_ff <= 1'b0;
         c2_vld_ff <= 1'b0;
         c3_vld_ff <= 1'b0;
         c4_vld_ff <= 1'b0;
      end else begin
         u1_vld_ff <= z_vld;
         u2_vld_ff <= u1_vld_ff;
         u3_vld_ff <= u2_vld_ff;
         c1_vld_ff <= u3_vld_ff;
         c2_vld_ff <= c1_vld_ff;
         c3_vld_ff <= x_vld;
         c4_vld_ff <= c3_vld_ff;
      end
   end

   // Translations: -round(dot(axis, eye)) for each row, rows indexed X, Y, Z.
   logic signed [UW-1:0]   ys_axis [3][3];
   logic signed [CW-1:0]   ys_eye  [3];
   logic signed [DP_W-1:0] d1_p_ff    [3][3];
   logic signed [UW-1:0]   d1_axis_ff [3][3];
   logic                   d1_ok_ff;
   logic                   d1_vld_ff;
   logic signed [DS_W-1:0] d2_sum_ff  [3];
   logic signed [UW-1:0]   d2_axis_ff [3][3];
   logic                   d2_ok_ff;
   logic                   d2_vld_ff;
   logic signed [CW-1:0]   d3_trans_ff [3];
   logic signed [UW-1:0]   d3_axis_ff  [3][3];
   logic                   d3_ok_ff;
   logic signed [CW-1:0]   d2_trans_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ys_eye[i]        = y_side[i * CW +: CW];
         ys_axis[ROW_X][i] = y_side[3 * CW + (3 + i) * UW +: UW];
         ys_axis[ROW_Y][i] = y_unit[i];
         ys_axis[ROW_Z][i] = y_side[3 * CW + i * UW +: UW];
      end
   end

   always_comb begin
      logic signed [DS_W:0] rnd;
      logic signed [DS_W:0] neg_t;
      for (int k = 0; k < 3; k++) begin
         rnd   = ((DS_W + 1)'(d2_sum_ff[k]) + T_HALF) >>> FRAC_BITS;
         neg_t = -rnd;
         if (neg_t > T_MAX) begin
            d2_trans_in[k] = T_MAX[CW-1:0];
         end else if (neg_t < T_MIN) begin
            d2_trans_in[k] = T_MIN[CW-1:0];
         end else begin
            d2_trans_in[k] = neg_t[CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         for (int i = 0; i < 3; i++) begin
            d1_p_ff[k][i]    <= ys_axis[k][i] * ys_eye[i];
            d1_axis_ff[k][i] <= ys_axis[k][i];
            d2_axis_ff[k][i] <= d1_axis_ff[k][i];
         end
         d2_sum_ff[k] <= DS_W'(d1_p_ff[k][0]) + DS_W'(d1_p_ff[k][1]) + DS_W'(d1_p_ff[k][2]);
      end
      d1_ok_ff <= y_side[CC_W-1] & y_nz;
      d2_ok_ff <= d1_ok_ff;
   end

   // The last stage holds the finished item while its three rows are shown.
   always_ff @(posedge clock) begin
      if (d2_vld_ff) begin
         d3_trans_ff <= d2_trans_in;
         d3_axis_ff  <= d2_axis_ff;
         d3_ok_ff    <= d2_ok_ff;
      end
   end

   logic    emit_ff;
   row_type row_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_vld_ff <= 1'b0;
         d2_vld_ff <= 1'b0;
         emit_ff   <= 1'b0;
         row_ff    <= ROW_X;
      end else begin
         d1_vld_ff <= y_vld;
         d2_vld_ff <= d1_vld_ff;
         if (d2_vld_ff) begin
            emit_ff <= 1'b1;
            row_ff  <= ROW_X;
         end else if (emit_ff) begin
            if (row_ff == ROW_Z) begin
               emit_ff <= 1'b0;
            end else begin
               row_ff <= row_ff + row_type'(1);
            end
         end
      end
   end

   // Row select; a degenerate item shows zero axes and translations.
   always_comb begin
      rsp_axis_a      = '0;
      rsp_axis_b      = '0;
      rsp_axis_c      = '0;
      rsp_translation = '0;
      case (row_ff)
         ROW_X, ROW_Y, ROW_Z: begin
            if (d3_ok_ff) begin
               rsp_axis_a      = d3_axis_ff[row_ff][0];
               rsp_axis_b      = d3_axis_ff[row_ff][1];
               rsp_axis_c      = d3_axis_ff[row_ff][2];
               rsp_translation = d3_trans_ff[row_ff];
            end
         end
         default: begin
            rsp_axis_a = '0;
         end
      endcase
   end

   assign rsp_strobe     = emit_ff;
   assign rsp_row_index  = row_ff;
   assign rsp_degenerate = ~d3_ok_ff;
   assign rsp_last_row   = (row_ff == ROW_Z);

endmodule
`default_nettype wire

/* tb/view_matrix_lookat_tb.sv */
// Self-checking testbench for the look-at view matrix generator.
`timescale 1ns / 1ps
`default_nettype none
module view_matrix_lookat_tb;
   import vml_pkg::*;

   localparam int FB  = 16;
   localparam int CW  = 32;
   localparam int AW  = FB + 2;
   // After the last expected row, the bench waits this long to catch any stray rows.
   localparam int DRAIN_CYCLES = 400;
   localparam int STALL_LIMIT  = 5000;
   localparam int RANDOM_ITEMS = 350;
   // Near the end of the stimulus the sender stops idling.
   localparam int NO_IDLE_TAIL = 40;

   typedef longint          vec3_type[3];
   typedef longint unsigned mag3_type[3];

   // One camera setup: eye, target and up, each three signed coordinates.
   typedef struct {
      logic signed [CW-1:0] eye[3];
      logic signed [CW-1:0] tgt[3];
      logic signed [CW-1:0] up[3];
   } camera_type;

   // One emitted view matrix row.
   typedef struct {
      row_type              row;
      logic signed [AW-1:0] axis[3];
      logic signed [CW-1:0] trans;
      logic                 degen;
      logic                 last;
   } matrix_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [CW-1:0] req_eye_x = '0, req_eye_y = '0, req_eye_z = '0;
   logic signed [CW-1:0] req_target_x = '0, req_target_y = '0, req_target_z = '0;
   logic signed [CW-1:0] req_upvec_x = '0, req_upvec_y = '0, req_upvec_z = '0;
   logic                 rsp_strobe;
   row_type              rsp_row_index;
   logic signed [AW-1:0] rsp_axis_a, rsp_axis_b, rsp_axis_c;
   logic signed [CW-1:0] rsp_translation;
   logic                 rsp_degenerate, rsp_last_row;

   view_matrix_lookat #(.FRAC_BITS(FB), .COORD_WIDTH(CW)) DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_eye_x(req_eye_x), .req_eye_y(req_eye_y), .req_eye_z(req_eye_z),
      .req_target_x(req_target_x), .req_target_y(req_target_y),
      .req_target_z(req_target_z),
      .req_upvec_x(req_upvec_x), .req_upvec_y(req_upvec_y), .req_upvec_z(req_upvec_z),
      .rsp_strobe(rsp_strobe), .rsp_row_index(rsp_row_index),
      .rsp_axis_a(rsp_axis_a), .rsp_axis_b(rsp_axis_b), .rsp_axis_c(rsp_axis_c),
      .rsp_translation(rsp_translation), .rsp_degenerate(rsp_degenerate),
      .rsp_last_row(rsp_last_row)
   );

   camera_type     pending_cameras[$];
   matrix_row_type expected_rows[$];
   camera_type     cur_camera;
   int          idle_left = 0;
   int          mismatches = 0;
   int          items_sent = 0;
   int          rows_seen = 0;
   int          degen_rows = 0;
   int          sat_rows = 0;
   int          quiet_cycles = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Predictor. It works on 64-bit magnitudes, which hold every product
   // that the normalizers and the dot product can form at these widths.
   // ------------------------------------------------------------------

   function automatic longint unsigned int_sqrt(input longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // Shift all magnitudes together until the largest lies in [2^29, 2^30).
   // Returns 0 for an all-zero vector.
   function automatic bit scale_vector(input vec3_type v, output mag3_type m,
                                       output bit ng[3]);
      longint unsigned mx;
      mx = 0;
      for (int i = 0; i < 3; i++) begin
         ng[i] = v[i] < 0;
         m[i] = ng[i] ? longint'(-v[i]) : longint'(v[i]);
         if (m[i] > mx) mx = m[i];
      end
      if (mx == 0) return 0;
      while (mx >= (64'd1 << SCALE_TOP)) begin
         mx >>= 1;
         for (int i = 0; i < 3; i++) m[i] >>= 1;
      end
      while (mx < (64'd1 << SCALE_LOW)) begin
         mx <<= 1;
         for (int i = 0; i < 3; i++) m[i] <<= 1;
      end
      return 1;
   endfunction

   // Unit vector in Q1.FB, rounded half away from zero.
   function automatic bit unit_vector(input vec3_type v, output vec3_type u);
      mag3_type m;
      bit    ng[3];
      longint unsigned len, q;
      u = '{0, 0, 0};
      if (!scale_vector(v, m, ng)) return 0;
      len = int_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
      if (len == 0) return 0;
      for (int i = 0; i < 3; i++) begin
         q = ((m[i] << FB) + (len >> 1)) / len;
         u[i] = ng[i] ? -longint'(q) : longint'(q);
      end
      return 1;
   endfunction

   function automatic vec3_type cross_product(input vec3_type a, input vec3_type b);
      vec3_type r;
      r[0] = a[1] * b[2] - a[2] * b[1];
      r[1] = a[2] * b[0] - a[0] * b[2];
      r[2] = a[0] * b[1] - a[1] * b[0];
      return r;
   endfunction

   // -dot(axis, eye), rounded by floor(x + 1/2), then saturated to CW bits.
   function automatic longint eye_offset(input vec3_type a, input vec3_type e);
      longint hi, lo, eh, t, lim;
      hi = 0;
      lo = 0;
      for (int i = 0; i < 3; i++) begin
         eh = e[i] >>> FB;
         hi += a[i] * eh;
         lo += a[i] * (e[i] - (eh <<< FB));
      end
      lo += longint'(1) <<< (FB - 1);
      t = -(hi + (lo >>> FB));
      lim = longint'(1) <<< (CW - 1);
      if (t > lim - 1) t = lim - 1;
      if (t < -lim) t = -lim;
      return t;
   endfunction

   // Builds the camera basis of one item and queues its three expected rows.
   function automatic void predict_rows(input camera_type c);
      vec3_type eye, dir, up, ups, axes[3];
      mag3_type m;
      bit      ng[3];
      bit      ok;
      row_type row_code[3];
      matrix_row_type r;
      row_code = '{ROW_X, ROW_Y, ROW_Z};
      for (int i = 0; i < 3; i++) begin
         eye[i] = longint'(c.eye[i]);
         dir[i] = eye[i] - longint'(c.tgt[i]);
         up[i]  = longint'(c.up[i]);
      end
      ok = unit_vector(dir, axes[2]);
      if (ok) begin
         // Only the direction of up matters, so it is scaled before the cross product.
         if (scale_vector(up, m, ng)) begin
            for (int i = 0; i < 3; i++) ups[i] = ng[i] ? -longint'(m[i]) : longint'(m[i]);
         end else begin
            ups = '{0, 0, 0};
         end
         ok = unit_vector(cross_product(ups, axes[2]), axes[0]);
      end
      if (ok) begin
         ok = unit_vector(cross_product(axes[2], axes[0]), axes[1]);
      end
      for (int k = 0; k < 3; k++) begin
         r.row = row_code[k];
         for (int i = 0; i < 3; i++) r.axis[i] = ok ? AW'(axes[k][i]) : '0;
         r.trans = ok ? CW'(eye_offset(axes[k], eye)) : '0;
         r.degen = !ok;
         r.last  = (k == 2);
         expected_rows.push_back(r);
      end
   endfunction

   // ------------------------------------------------------------------
   // Stimulus.
   // ------------------------------------------------------------------

   function automatic camera_type make_camera(input longint e0, e1, e2, t0, t1, t2,
                                              u0, u1, u2);
      camera_type c;
      c.eye = '{CW'(e0), CW'(e1), CW'(e2)};
      c.tgt = '{CW'(t0), CW'(t1), CW'(t2)};
      c.up  = '{CW'(u0), CW'(u1), CW'(u2)};
      return c;
   endfunction

   function automatic logic signed [CW-1:0] small_coord();
      return CW'(longint'($urandom_range(0, 1 << 21)) - (1 << 20));
   endfunction

   function automatic camera_type random_camera();
      camera_type c;
      int      kind, mul;
      kind = $urandom_range(0, 99);
      for (int i = 0; i < 3; i++) begin
         c.eye[i] = $urandom;
         c.tgt[i] = $urandom;
         c.up[i]  = $urandom;
      end
      if (kind >= 45) begin
         // Everyday scenes: coordinates within 16 units of the origin.
         for (int i = 0; i < 3; i++) begin
            c.eye[i] = small_coord();
            c.tgt[i] = small_coord();
            c.up[i]  = small_coord();
         end
      end
      if (kind >= 80 && kind < 88) begin
         // Up along the view direction leaves X without length.
         mul = $urandom_range(1, 3) * ($urandom_range(0, 1) ? 1 : -1);
         for (int i = 0; i < 3; i++) c.up[i] = (c.eye[i] - c.tgt[i]) * mul;
      end else if (kind >= 88 && kind < 93) begin
         c.tgt = c.eye;
      end else if (kind >= 93 && kind < 96) begin
         c.up = '{0, 0, 0};
      end else if (kind >= 96) begin
         // A far-away eye, whose translation may overflow the coordinate range.
         for (int i = 0; i < 3; i++) begin
            c.eye[i] = $urandom_range(0, 1) ? 32'h7FFF0000 + $urandom_range(0, 65535)
                                            : 32'h80000000 + $urandom_range(0, 65535);
         end
      end
      return c;
   endfunction

   // ------------------------------------------------------------------
   // Driver: holds an item until it is taken, then moves to the next one,
   // sometimes after a short idle burst.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && busy)) begin
         if (start) begin
            predict_rows(cur_camera);
            items_sent++;
         end
         if (idle_left > 0) begin
            idle_left--;
            start <= 1'b0;
         end else if (pending_cameras.size() > 0) begin
            cur_camera = pending_cameras.pop_front();
            req_eye_x    <= cur_camera.eye[0];
            req_eye_y    <= cur_camera.eye[1];
            req_eye_z    <= cur_camera.eye[2];
            req_target_x <= cur_camera.tgt[0];
            req_target_y <= cur_camera.tgt[1];
            req_target_z <= cur_camera.tgt[2];
            req_upvec_x  <= cur_camera.up[0];
            req_upvec_y  <= cur_camera.up[1];
            req_upvec_z  <= cur_camera.up[2];
            start <= 1'b1;
            if (pending_cameras.size() > NO_IDLE_TAIL && $urandom_range(0, 3) == 0) begin
               idle_left = $urandom_range(1, 3);
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: every strobed row is compared with the oldest expected row.
   // A watchdog ends the run when nothing moves for too long.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      matrix_row_type want;
      bit          bad;
      if (!reset) begin
         if (rsp_strobe) begin
            rows_seen++;
            if (rsp_degenerate) degen_rows++;
            if (rsp_translation == {1'b0, {(CW-1){1'b1}}} ||
                rsp_translation == {1'b1, {(CW-1){1'b0}}}) sat_rows++;
            if (expected_rows.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("ERROR: row %0d came with no item pending",
                                              rsp_row_index);
            end else begin
               want = expected_rows.pop_front();
               bad = rsp_row_index !== want.row || rsp_axis_a !== want.axis[0] ||
                     rsp_axis_b !== want.axis[1] || rsp_axis_c !== want.axis[2] ||
                     rsp_translation !== want.trans || rsp_degenerate !== want.degen ||
                     rsp_last_row !== want.last;
               if (bad) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("ERROR: row mismatch at %0t", $realtime);
                     $display("  expected row %0d axis %0d %0d %0d trans %0d degen %0b last %0b",
                              want.row, want.axis[0], want.axis[1], want.axis[2],
                              want.trans, want.degen, want.last);
                     $display("  actual   row %0d axis %0d %0d %0d trans %0d degen %0b last %0b",
                              rsp_row_index, rsp_axis_a, rsp_axis_b, rsp_axis_c,
                              rsp_translation, rsp_degenerate, rsp_last_row);
                  end
               end
            end
         end
         if (rsp_strobe || (start && !busy)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
               $display("watchdog: no activity for %0d cycles", STALL_LIMIT);
               $display("end of test: mismatches");
               $finish;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Test sequence: directed cameras first, then random ones.
   // ------------------------------------------------------------------
   initial begin
      longint mx, mn, one;
      mx  = 64'sh7FFFFFFF;
      mn  = -64'sh80000000;
      one = 64'sh10000;
      // A plain camera on the Z axis looking at the origin.
      pending_cameras.push_back(make_camera(0, 0, 5 * one, 0, 0, 0, 0, one, 0));
      // Looking along the X and Y axes, the first with an up that is not quite perpendicular.
      pending_cameras.push_back(make_camera(3 * one, 0, 0, 0, 0, 0, one, one, 0));
      pending_cameras.push_back(make_camera(0, -one, 0, 0, 0, 0, 0, 0, -one));
      // Eye equal to target.
      pending_cameras.push_back(make_camera(one, 2 * one, 3 * one, one, 2 * one, 3 * one,
                                            0, one, 0));
      pending_cameras.push_back(make_camera(mx, mn, 0, mx, mn, 0, 0, one, 0));
      // Zero up vector and up parallel or antiparallel to the view direction.
      pending_cameras.push_back(make_camera(one, one, one, 0, 0, 0, 0, 0, 0));
      pending_cameras.push_back(make_camera(one, 2 * one, 0, 0, 0, 0, 2, 4, 0));
      pending_cameras.push_back(make_camera(0, 0, one, 0, 0, 0, 0, 0, mn));
      // Extreme coordinates and the largest possible eye-target difference.
      pending_cameras.push_back(make_camera(mx, mx, mx, mn, mn, mn, mn, mx, 0));
      pending_cameras.push_back(make_camera(mn, mn, mn, mx, mx, mx, mx, mn, mx));
      pending_cameras.push_back(make_camera(mx, 0, 0, mn, 0, 0, 0, mx, 0));
      // Tiny vectors of a single least significant bit.
      pending_cameras.push_back(make_camera(1, 0, 0, 0, 0, 0, 0, 1, 0));
      pending_cameras.push_back(make_camera(0, -1, 1, 0, 0, 0, -1, 0, 1));
      // Translation overflow in both directions.
      pending_cameras.push_back(make_camera(mx, mx, mx, 0, 0, 0, 0, one, 0));
      pending_cameras.push_back(make_camera(mn, mn, mn, 0, 0, 0, 0, one, 0));
      pending_cameras.push_back(make_camera(mx, mn, mx, mx - one, mn + one, mx - one,
                                            -1, 0, 0));
      // All bits toggling in every field.
      pending_cameras.push_back(make_camera(-1, -1, -1, 0, 0, 0, -1, 0, -1));
      pending_cameras.push_back(make_camera(64'h55555555, 64'h2AAAAAAA, 64'h55555555,
                                            mn, mn, mn, 64'h2AAAAAAA, -1, 1));
      for (int i = 0; i < RANDOM_ITEMS; i++) pending_cameras.push_back(random_camera());

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock); while (pending_cameras.size() > 0 || start);
      do @(posedge clock); while (expected_rows.size() > 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d camera setups and checked %0d matrix rows,", items_sent, rows_seen);
      $display("of which %0d were degenerate and %0d had a saturated translation.",
               degen_rows, sat_rows);
      if (mismatches == 0 && expected_rows.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d mismatches, %0d rows never came", mismatches, expected_rows.size());
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
`default_nettype wire
